@@ rtl/core/lru_buffer_manager_assert.svh @@
// ----------------------------------------------------------------------------
// lru_buffer_manager_assert
// Clocked assertion macros for the buffer manager, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_MANAGER_ASSERT_SVH
`define LRU_BUFFER_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define LBM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBM_ASSERT(label, clk, rst_n, prop, msg)
`define LBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/lbm_pkg.sv @@
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types, codes and defaults of the buffer manager.
// ----------------------------------------------------------------------------
`default_nettype none
package lbm_pkg;
  localparam int unsigned EntriesDef = 16;
  localparam int unsigned PinBitsDef = 8;
  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxInW = 4;
  localparam int unsigned PinOutW = 8;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0, KIND_ACCESS = 2'd1, KIND_DONE = 2'd2, KIND_FREE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_MISMATCH = 3'd1, ST_IN_USE = 3'd2, ST_NO_ENTRY = 3'd3,
    ST_NOT_PINNED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_UNLINK, S_LINK, S_APPLY, S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic unlink;
    logic link;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic need_unlink;
    logic need_link;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/core/lbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbm_ctrl
// Sequencer: load, decide, unlink or link, apply, present the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lbm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire lbm_pkg::sts_t  sts_i,
  output lbm_pkg::cmd_t       cmd_o
);
  lbm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lbm_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lbm_pkg::S_IDLE:   if (in_valid_i) state_d = lbm_pkg::S_DECIDE;
      lbm_pkg::S_DECIDE: begin
        if (sts_i.need_unlink) state_d = lbm_pkg::S_UNLINK;
        else if (sts_i.need_link) state_d = lbm_pkg::S_LINK;
        else state_d = lbm_pkg::S_APPLY;
      end
      lbm_pkg::S_UNLINK: state_d = lbm_pkg::S_APPLY;
      lbm_pkg::S_LINK:   state_d = lbm_pkg::S_APPLY;
      lbm_pkg::S_APPLY:  state_d = lbm_pkg::S_OUT;
      lbm_pkg::S_OUT:    if (out_ready_i) state_d = lbm_pkg::S_IDLE;
      default:           state_d = lbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == lbm_pkg::S_IDLE);
    out_valid_o = (state_q == lbm_pkg::S_OUT);
    cmd_o.load   = in_ready_o && in_valid_i;
    cmd_o.decide = (state_q == lbm_pkg::S_DECIDE);
    cmd_o.unlink = (state_q == lbm_pkg::S_UNLINK);
    cmd_o.link   = (state_q == lbm_pkg::S_LINK);
    cmd_o.apply  = (state_q == lbm_pkg::S_APPLY);
  end
endmodule
`default_nettype wire

@@ rtl/core/lbm_datapath.sv @@
// ----------------------------------------------------------------------------
// lbm_datapath
// Entry table, LRU links, free stack and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module lbm_datapath #(
  parameter int unsigned ENTRIES  = lbm_pkg::EntriesDef,
  parameter int unsigned PIN_BITS = lbm_pkg::PinBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lbm_pkg::cmd_t               cmd_i,
  output lbm_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [lbm_pkg::KeyW-1:0]    key_i,
  input  wire logic [lbm_pkg::IdxInW-1:0]  entry_index_i,
  output logic [lbm_pkg::IdxInW-1:0]       result_index_o,
  output logic [2:0]                       status_o,
  output logic                             evicted_o,
  output logic [lbm_pkg::KeyW-1:0]         evicted_key_o,
  output logic [lbm_pkg::PinOutW-1:0]      pin_count_o
);
  localparam int unsigned IW = $clog2(ENTRIES + 1);   // link width with null
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] Nil = IW'(ENTRIES);
  localparam logic [PIN_BITS-1:0] PinMax = '1;
  localparam int unsigned KW = lbm_pkg::KeyW;

  logic [KW-1:0]       key_q [ENTRIES];
  logic [PIN_BITS-1:0] pins_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [IW-1:0]       prev_q [ENTRIES];
  logic [IW-1:0]       next_q [ENTRIES];
  logic [IW-1:0]       front_q, rear_q;
  logic [IW-1:0]       count_q;
  logic [EW-1:0]       stack_q [ENTRIES];
  logic [IW-1:0]       fcount_q;

  // latched item
  logic [1:0]    kind_q;
  logic [KW-1:0] ikey_q;
  logic [lbm_pkg::IdxInW-1:0] iidx_q;

  // decision registers
  logic [EW-1:0] tgt_q;
  logic          tgt_ok_q;
  logic [2:0]    st_q;
  logic          ev_q;
  logic [KW-1:0] evk_q;
  logic          pop_q, push_q;
  logic [PIN_BITS-1:0] newpins_q;
  logic [IW-1:0] up_q, un_q;   // captured neighbors

  // result registers
  logic [lbm_pkg::IdxInW-1:0] ridx_q;
  logic [2:0]                 rst_q;
  logic                       rev_q;
  logic [KW-1:0]              revk_q;
  logic [lbm_pkg::PinOutW-1:0] rpin_q;

  // decide logic
  logic [EW-1:0] d_tgt;
  logic          d_ok, d_pop, d_push, d_unl, d_lnk, d_ev, d_inrange, d_onlist;
  logic [2:0]    d_st;
  logic [PIN_BITS-1:0] d_pins, cur_pins;
  logic [IW-1:0] top_idx;

  always_comb begin
    top_idx   = fcount_q - IW'(1);
    d_inrange = ({{(32-lbm_pkg::IdxInW){1'b0}}, iidx_q} < 32'(ENTRIES));
    d_tgt     = EW'(iidx_q);
    d_ok = 1'b0; d_pop = 1'b0; d_push = 1'b0; d_unl = 1'b0; d_lnk = 1'b0;
    d_ev = 1'b0; d_st = lbm_pkg::ST_OK;
    cur_pins = pins_q[d_tgt];
    d_pins = cur_pins;
    d_onlist = (front_q == IW'(d_tgt)) || (prev_q[d_tgt] != Nil);
    case (lbm_pkg::kind_e'(kind_q))
      lbm_pkg::KIND_ALLOC: begin
        d_pins = '0;
        if (fcount_q != '0 && fcount_q <= IW'(ENTRIES)) begin
          d_tgt = stack_q[top_idx[EW-1:0]]; d_ok = 1'b1; d_pop = 1'b1;
        end else if (rear_q != Nil) begin
          d_tgt = rear_q[EW-1:0]; d_ok = 1'b1; d_unl = 1'b1; d_ev = 1'b1;
        end else begin
          d_st = lbm_pkg::ST_NO_ENTRY;
        end
      end
      default: begin
        if (!d_inrange || !valid_q[d_tgt]) begin
          d_st = lbm_pkg::ST_NO_ENTRY;
        end else if (kind_q == lbm_pkg::KIND_ACCESS) begin
          if (key_q[d_tgt] != ikey_q) d_st = lbm_pkg::ST_MISMATCH;
          else if (cur_pins == '0) begin
            d_ok = 1'b1; d_pins = PIN_BITS'(1); d_unl = d_onlist;
          end else begin
            d_ok = 1'b1;
            if (cur_pins != PinMax) d_pins = cur_pins + PIN_BITS'(1);
          end
        end else if (kind_q == lbm_pkg::KIND_DONE) begin
          if (cur_pins == '0) d_st = lbm_pkg::ST_NOT_PINNED;
          else begin
            d_ok = 1'b1; d_pins = cur_pins - PIN_BITS'(1);
            d_lnk = (d_pins == '0);
          end
        end else begin
          if (key_q[d_tgt] != ikey_q) d_st = lbm_pkg::ST_MISMATCH;
          else if (cur_pins != '0) d_st = lbm_pkg::ST_IN_USE;
          else begin
            d_ok = 1'b1; d_unl = d_onlist; d_push = (fcount_q < IW'(ENTRIES));
          end
        end
      end
    endcase
  end

  always_comb begin
    sts_o.need_unlink = d_unl;
    sts_o.need_link   = d_lnk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      front_q  <= Nil;
      rear_q   <= Nil;
      count_q  <= '0;
      fcount_q <= IW'(ENTRIES);
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i]   <= '0;
        pins_q[i]  <= '0;
        prev_q[i]  <= Nil;
        next_q[i]  <= Nil;
        stack_q[i] <= EW'(i);
      end
    end else begin
      if (cmd_i.unlink) begin
        // splice the target out of the list
        if (up_q != Nil) next_q[up_q[EW-1:0]] <= un_q; else front_q <= un_q;
        if (un_q != Nil) prev_q[un_q[EW-1:0]] <= up_q; else rear_q <= up_q;
        prev_q[tgt_q] <= Nil;
        next_q[tgt_q] <= Nil;
        if (count_q != '0) count_q <= count_q - IW'(1);
      end
      if (cmd_i.link) begin
        prev_q[tgt_q] <= Nil;
        next_q[tgt_q] <= front_q;
        if (front_q != Nil) prev_q[front_q[EW-1:0]] <= IW'(tgt_q);
        else rear_q <= IW'(tgt_q);
        front_q <= IW'(tgt_q);
        count_q <= count_q + IW'(1);
      end
      if (cmd_i.apply && tgt_ok_q) begin
        pins_q[tgt_q] <= newpins_q;
        if (kind_q == lbm_pkg::KIND_ALLOC) begin
          key_q[tgt_q]   <= ikey_q;
          valid_q[tgt_q] <= 1'b1;
          prev_q[tgt_q]  <= Nil;
          next_q[tgt_q]  <= Nil;
          if (pop_q) fcount_q <= fcount_q - IW'(1);
        end else if (kind_q == lbm_pkg::KIND_FREE) begin
          valid_q[tgt_q] <= 1'b0;
          if (push_q) begin
            stack_q[fcount_q[EW-1:0]] <= tgt_q;
            fcount_q <= fcount_q + IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      ikey_q <= key_i;
      iidx_q <= entry_index_i;
    end
    if (cmd_i.decide) begin
      tgt_q     <= d_tgt;
      tgt_ok_q  <= d_ok;
      st_q      <= d_st;
      ev_q      <= d_ev;
      evk_q     <= d_ev ? key_q[d_tgt] : '0;
      pop_q     <= d_pop;
      push_q    <= d_push;
      newpins_q <= d_pins;
      up_q      <= prev_q[d_tgt];
      un_q      <= next_q[d_tgt];
    end
    if (cmd_i.apply) begin
      if (kind_q == lbm_pkg::KIND_ALLOC)
        ridx_q <= tgt_ok_q ? lbm_pkg::IdxInW'(tgt_q) : '0;
      else
        ridx_q <= iidx_q;
      rst_q  <= st_q;
      rev_q  <= ev_q;
      revk_q <= evk_q;
      if (kind_q == lbm_pkg::KIND_ALLOC || st_q == lbm_pkg::ST_NO_ENTRY)
        rpin_q <= '0;
      else
        rpin_q <= lbm_pkg::PinOutW'(tgt_ok_q ? newpins_q : pins_q[tgt_q]);
    end
  end

  assign result_index_o = ridx_q;
  assign status_o       = rst_q;
  assign evicted_o      = rev_q;
  assign evicted_key_o  = revk_q;
  assign pin_count_o    = rpin_q;
endmodule
`default_nettype wire

@@ rtl/core/lru_buffer_manager.sv @@
// ----------------------------------------------------------------------------
// lru_buffer_manager
// Buffer pool with free stack and LRU eviction list.
// ----------------------------------------------------------------------------
// channel  handshake               payload
// in       in_valid_i/in_ready_o   kind_i, key_i, entry_index_i
// out      out_valid_o/out_ready_i result_index_o, status_o, evicted_o,
//                                  evicted_key_o, pin_count_o
// An item passes through accept, decide, apply and present, with an unlink
// from or a link into the LRU list between decide and apply when needed; the
// sequencer holds one item at a time.
// Reset clears all entries, links and refills the free stack at once.
// A stall on out holds the result and keeps in_ready_o low.
`default_nettype none
`include "lru_buffer_manager_assert.svh"
module lru_buffer_manager #(
  parameter int unsigned ENTRIES  = lbm_pkg::EntriesDef,
  parameter int unsigned PIN_BITS = lbm_pkg::PinBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [lbm_pkg::KeyW-1:0]    key_i,
  input  wire logic [lbm_pkg::IdxInW-1:0]  entry_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [lbm_pkg::IdxInW-1:0]       result_index_o,
  output logic [2:0]                       status_o,
  output logic                             evicted_o,
  output logic [lbm_pkg::KeyW-1:0]         evicted_key_o,
  output logic [lbm_pkg::PinOutW-1:0]      pin_count_o
);
  lbm_pkg::cmd_t cmd;
  lbm_pkg::sts_t sts;

  lbm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lbm_datapath #(.ENTRIES(ENTRIES), .PIN_BITS(PIN_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .key_i, .entry_index_i,
    .result_index_o, .status_o, .evicted_o, .evicted_key_o, .pin_count_o
  );

  `LBM_ASSERT(a_not_both, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while result held")
  `LBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(evicted_key_o), "result dropped while stalled")
  `LBM_ASSERT(a_ev_status, clk_i, rst_ni, !(out_valid_o && evicted_o && status_o != lbm_pkg::ST_OK), "evicted with error")
endmodule
`default_nettype wire
